// ===== sv/jac_pkg.sv =====
// Shared types and constants for the joystick axis conditioner.
// Stand-alone package with no dependencies; the top level imports it.

package jac_pkg;

    // Fixed field widths.
    localparam int SAMPLE_W   = 12;
    localparam int PCT_W      = 8;
    localparam int DZ_W       = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    // Defaults for the top level parameters.
    localparam int WINDOW_DEF     = 8;
    localparam int FULL_SCALE_DEF = 4095;

    // Full deflection in percent, and the width of the scaled numerator
    // (4095 * 100 fits in 19 bits).
    localparam int PCT_MAX   = 100;
    localparam int PCT_NUM_W = 19;

    // Register reset values.
    localparam logic [SAMPLE_W-1:0] CENTER_RST = 12'd2048;
    localparam logic [DZ_W-1:0]     DZ_RST     = 7'd5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_REST_X    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REST_Y    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE = 2'd2;

    // Request operation codes.
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_PRIME  = 1'b1;

    // Sequencer states.
    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_READ   = 6'b000010,
        ST_SETUP  = 6'b000100,
        ST_DIV    = 6'b001000,
        ST_FINISH = 6'b010000,
        ST_DONE   = 6'b100000
    } state_t;

endpackage

// ===== sv/jac_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.

module jac_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 8
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

// ===== sv/joystick_axis_conditioner_unit.sv =====
// Joystick axis conditioner: moving average, center mapping and dead zone.
// Depends on jac_pkg and on jac_ram for the sample windows.
//
//   Channel   Signals                                 Direction  Payload
//   -------   -------------------------------------   ---------  ---------------------------
//   input     in_valid / in_stall                     in / out   operation, sample_x/y
//   output    out_valid / out_stall                   out / in   pos_x, pos_y
//   config    cfg_write, cfg_index, cfg_data          in         rest_x/y, dead_zone
//
// A sample request passes through ST_READ, then ST_SETUP, ST_DIV and ST_FINISH for each
// axis, then ST_DONE. The restoring divider retires one quotient bit per cycle of the
// DW = 19 bit numerator and runs once per axis; the mean is one reciprocal multiply.
// A prime request goes straight to ST_DONE. Reset is asynchronous and active low; per-entry
// valid bits make the windows read as 2048 at once. A result waits in the output
// register while out_stall is high, and the next one waits in the work registers.

module joystick_axis_conditioner_unit #(
    parameter int WINDOW     = jac_pkg::WINDOW_DEF,
    parameter int FULL_SCALE = jac_pkg::FULL_SCALE_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // Request channel
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             operation,
    input  logic [jac_pkg::SAMPLE_W-1:0]     sample_x,
    input  logic [jac_pkg::SAMPLE_W-1:0]     sample_y,
    // Result channel
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic signed [jac_pkg::PCT_W-1:0] pos_x,
    output logic signed [jac_pkg::PCT_W-1:0] pos_y,
    // Configuration write port
    input  logic                             cfg_write,
    input  logic [jac_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [jac_pkg::CFG_DATA_W-1:0]   cfg_data
);

    import jac_pkg::*;

    // Derived widths. The window index needs at least one bit, the running
    // total holds WINDOW full-scale samples, and the divider is sized for
    // the percent numerator (|mean - center| * 100).
    localparam int SLOT_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int TOTAL_W = SAMPLE_W + $clog2(WINDOW);
    localparam int DIVD_W  = PCT_NUM_W;
    localparam int FS_W    = $clog2(FULL_SCALE + 1);
    localparam int DIVS_W  = (FS_W > SAMPLE_W) ? FS_W : SAMPLE_W;
    localparam int CNT_W   = $clog2(DIVD_W + 1);

    // The mean is total * ceil(2^SH / WINDOW) >> SH with SH = TOTAL_W +
    // ceil(log2(WINDOW)), which is exact for every total below 2^TOTAL_W.
    localparam int WIN_LOG  = $clog2(WINDOW);
    localparam int RECIP_SH = TOTAL_W + WIN_LOG;
    localparam int RECIP_W  = TOTAL_W + 2;
    localparam int PROD_W   = TOTAL_W + RECIP_W;

    localparam logic [SLOT_W-1:0]  LAST_SLOT = SLOT_W'(WINDOW - 1);
    localparam logic [TOTAL_W-1:0] WIN_T     = TOTAL_W'(WINDOW);
    localparam logic [TOTAL_W-1:0] TOTAL_RST = TOTAL_W'(int'(CENTER_RST) * WINDOW);
    localparam logic [RECIP_W-1:0] RECIP     =
        RECIP_W'(((1 << RECIP_SH) + WINDOW - 1) / WINDOW);
    localparam logic [DIVS_W:0]    FS_K      = (DIVS_W + 1)'(FULL_SCALE);
    localparam logic [DIVD_W-1:0]  PCT_SCALE = DIVD_W'(PCT_MAX);
    localparam logic [DZ_W-1:0]    PCT_CLAMP = DZ_W'(PCT_MAX);
    localparam logic [CNT_W-1:0]   DIV_STEPS = CNT_W'(DIVD_W);

    // Control state (reset).
    state_t                state_reg, state_next;
    logic [SAMPLE_W-1:0]   rest_x_reg, rest_x_next;
    logic [SAMPLE_W-1:0]   rest_y_reg, rest_y_next;
    logic [DZ_W-1:0]       dead_zone_reg, dead_zone_next;
    logic [SLOT_W-1:0]     slot_reg, slot_next;
    logic [WINDOW-1:0]     valid_reg, valid_next;
    logic [SAMPLE_W-1:0]   fill_x_reg, fill_x_next;
    logic [SAMPLE_W-1:0]   fill_y_reg, fill_y_next;
    logic [TOTAL_W-1:0]    total_x_reg, total_x_next;
    logic [TOTAL_W-1:0]    total_y_reg, total_y_next;
    logic                  axis_reg, axis_next;
    logic                  phase_reg, phase_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  out_valid_reg, out_valid_next;

    // Datapath registers (no reset).
    logic [SAMPLE_W-1:0]   samp_x_reg, samp_x_next;
    logic [SAMPLE_W-1:0]   samp_y_reg, samp_y_next;
    logic [SAMPLE_W-1:0]   mean_reg, mean_next;
    logic [DIVS_W-1:0]     rem_reg, rem_next;
    logic [DIVD_W-1:0]     quo_reg, quo_next;
    logic [DIVS_W-1:0]     dvs_reg, dvs_next;
    logic                  neg_reg, neg_next;
    logic                  zdiv_reg, zdiv_next;
    logic [PCT_W-1:0]      res_x_reg, res_x_next;
    logic [PCT_W-1:0]      res_y_reg, res_y_next;
    logic [PCT_W-1:0]      pos_x_reg, pos_x_next;
    logic [PCT_W-1:0]      pos_y_reg, pos_y_next;

    // Window memory: both axes share one row, X in the upper half.
    logic                      ram_we;
    logic [2*SAMPLE_W-1:0]     ram_wdata;
    logic [2*SAMPLE_W-1:0]     ram_rdata;
    logic [SAMPLE_W-1:0]       old_x;
    logic [SAMPLE_W-1:0]       old_y;

    // Mean terms.
    logic [TOTAL_W-1:0]        mean_total;
    logic [PROD_W-1:0]         mean_prod;

    // Percent setup terms.
    logic [SAMPLE_W-1:0]       ctr;
    logic                      mean_gt;
    logic [SAMPLE_W-1:0]       dev;
    logic [DIVD_W-1:0]         pct_num;
    logic [DIVS_W:0]           fs_diff;
    logic [DIVS_W:0]           fs_diff_neg;
    logic [DIVS_W-1:0]         pct_div;
    logic                      pct_neg;

    // Divider step terms.
    logic [DIVS_W:0]           rem_sh;
    logic [DIVS_W:0]           rem_sub;
    logic                      fits;

    // Percent finish terms.
    logic [DZ_W-1:0]           mag_clamp;
    logic [DZ_W-1:0]           mag;
    logic [PCT_W-1:0]          pct_val;

    logic                      in_accept;
    logic                      out_free;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign pos_x     = pos_x_reg;
    assign pos_y     = pos_y_reg;

    assign ram_we    = (state_reg == ST_READ);
    assign ram_wdata = {samp_x_reg, samp_y_reg};

    jac_ram #(
        .WIDTH (2 * SAMPLE_W),
        .DEPTH (WINDOW)
    ) u_window (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_reg),
        .wdata (ram_wdata),
        .raddr (slot_reg),
        .rdata (ram_rdata)
    );

    // An entry that has not been written since reset or the last prime
    // holds the fill value of its axis.
    assign old_x = valid_reg[slot_reg] ? ram_rdata[2*SAMPLE_W-1:SAMPLE_W] : fill_x_reg;
    assign old_y = valid_reg[slot_reg] ? ram_rdata[SAMPLE_W-1:0] : fill_y_reg;

    // Window mean of the axis in work.
    always_comb
    begin
        mean_total = axis_reg ? total_y_reg : total_x_reg;
        mean_prod  = PROD_W'(mean_total) * RECIP;
    end

    // Above the center the span is FULL_SCALE - center, which turns negative
    // when the center sits above full scale; at or below it the span is the
    // center itself. The quotient sign follows from both signs, and the Y
    // axis is inverted on top of that.
    always_comb
    begin
        ctr         = axis_reg ? rest_y_reg : rest_x_reg;
        mean_gt     = (mean_reg > ctr);
        dev         = mean_gt ? (mean_reg - ctr) : (ctr - mean_reg);
        pct_num     = DIVD_W'(dev) * PCT_SCALE;
        fs_diff     = FS_K - (DIVS_W + 1)'(ctr);
        fs_diff_neg = ~fs_diff + 1'b1;
        if (mean_gt)
        begin
            pct_div = fs_diff[DIVS_W] ? fs_diff_neg[DIVS_W-1:0] : fs_diff[DIVS_W-1:0];
            pct_neg = fs_diff[DIVS_W];
        end
        else
        begin
            pct_div = DIVS_W'(ctr);
            pct_neg = 1'b1;
        end
    end

    // One restoring division step per cycle.
    always_comb
    begin
        rem_sh  = {rem_reg, quo_reg[DIVD_W-1]};
        fits    = (rem_sh >= {1'b0, dvs_reg});
        rem_sub = rem_sh - {1'b0, dvs_reg};
    end

    // Clamp to full deflection, then apply the dead zone and the sign.
    always_comb
    begin
        mag_clamp = (quo_reg > PCT_SCALE) ? PCT_CLAMP : quo_reg[DZ_W-1:0];
        mag       = (zdiv_reg || (mag_clamp <= dead_zone_reg)) ? '0 : mag_clamp;
        pct_val   = neg_reg ? (~{1'b0, mag} + 1'b1) : {1'b0, mag};
    end

    always_comb
    begin
        state_next     = state_reg;
        rest_x_next    = rest_x_reg;
        rest_y_next    = rest_y_reg;
        dead_zone_next = dead_zone_reg;
        slot_next      = slot_reg;
        valid_next     = valid_reg;
        fill_x_next    = fill_x_reg;
        fill_y_next    = fill_y_reg;
        total_x_next   = total_x_reg;
        total_y_next   = total_y_reg;
        axis_next      = axis_reg;
        phase_next     = phase_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        samp_x_next    = samp_x_reg;
        samp_y_next    = samp_y_reg;
        mean_next      = mean_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        dvs_next       = dvs_reg;
        neg_next       = neg_reg;
        zdiv_next      = zdiv_reg;
        res_x_next     = res_x_reg;
        res_y_next     = res_y_reg;
        pos_x_next     = pos_x_reg;
        pos_y_next     = pos_y_reg;

        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_REST_X:    rest_x_next    = cfg_data[SAMPLE_W-1:0];
                CFG_REST_Y:    rest_y_next    = cfg_data[SAMPLE_W-1:0];
                CFG_DEAD_ZONE: dead_zone_next = cfg_data[DZ_W-1:0];
                default:       ;
            endcase
        end

        if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (operation == OP_PRIME)
                    begin
                        // Every entry now reads as the current center.
                        valid_next   = '0;
                        fill_x_next  = rest_x_reg;
                        fill_y_next  = rest_y_reg;
                        total_x_next = TOTAL_W'(rest_x_reg) * WIN_T;
                        total_y_next = TOTAL_W'(rest_y_reg) * WIN_T;
                        res_x_next   = '0;
                        res_y_next   = '0;
                        state_next   = ST_DONE;
                    end
                    else
                    begin
                        samp_x_next = sample_x;
                        samp_y_next = sample_y;
                        axis_next   = 1'b0;
                        phase_next  = 1'b0;
                        state_next  = ST_READ;
                    end
                end
            end

            ST_READ:
            begin
                total_x_next         = total_x_reg - TOTAL_W'(old_x) + TOTAL_W'(samp_x_reg);
                total_y_next         = total_y_reg - TOTAL_W'(old_y) + TOTAL_W'(samp_y_reg);
                valid_next[slot_reg] = 1'b1;
                slot_next            = (slot_reg == LAST_SLOT) ? '0 : slot_reg + 1'b1;
                state_next           = ST_SETUP;
            end

            ST_SETUP:
            begin
                if (!phase_reg)
                begin
                    // First pass: take the window mean of this axis.
                    mean_next  = mean_prod[RECIP_SH +: SAMPLE_W];
                    phase_next = 1'b1;
                end
                else
                begin
                    rem_next   = '0;
                    cnt_next   = DIV_STEPS;
                    quo_next   = pct_num;
                    dvs_next   = pct_div;
                    zdiv_next  = (pct_div == '0);
                    neg_next   = pct_neg ^ axis_reg;
                    state_next = ST_DIV;
                end
            end

            ST_DIV:
            begin
                rem_next = fits ? rem_sub[DIVS_W-1:0] : rem_sh[DIVS_W-1:0];
                quo_next = {quo_reg[DIVD_W-2:0], fits};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                if (!axis_reg)
                begin
                    res_x_next = pct_val;
                    axis_next  = 1'b1;
                    phase_next = 1'b0;
                    state_next = ST_SETUP;
                end
                else
                begin
                    res_y_next = pct_val;
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (out_free)
                begin
                    pos_x_next     = res_x_reg;
                    pos_y_next     = res_y_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rest_x_reg    <= CENTER_RST;
            rest_y_reg    <= CENTER_RST;
            dead_zone_reg <= DZ_RST;
            slot_reg      <= '0;
            valid_reg     <= '0;
            fill_x_reg    <= CENTER_RST;
            fill_y_reg    <= CENTER_RST;
            total_x_reg   <= TOTAL_RST;
            total_y_reg   <= TOTAL_RST;
            axis_reg      <= 1'b0;
            phase_reg     <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rest_x_reg    <= rest_x_next;
            rest_y_reg    <= rest_y_next;
            dead_zone_reg <= dead_zone_next;
            slot_reg      <= slot_next;
            valid_reg     <= valid_next;
            fill_x_reg    <= fill_x_next;
            fill_y_reg    <= fill_y_next;
            total_x_reg   <= total_x_next;
            total_y_reg   <= total_y_next;
            axis_reg      <= axis_next;
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        samp_x_reg <= samp_x_next;
        samp_y_reg <= samp_y_next;
        mean_reg   <= mean_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        dvs_reg    <= dvs_next;
        neg_reg    <= neg_next;
        zdiv_reg   <= zdiv_next;
        res_x_reg  <= res_x_next;
        res_y_reg  <= res_y_next;
        pos_x_reg  <= pos_x_next;
        pos_y_reg  <= pos_y_next;
    end

endmodule
